/* rtl/core/gli_pkg.sv */
// shared constants, types and register map of the galvo line interpolator
package gli_pkg;

    localparam int FRAC_BITS = 4;
    localparam int MAX_STEPS = 64;

    localparam int DAC_W     = 12;
    localparam int DAC_MAX   = 4095;
    localparam int TGT_W     = 16;
    localparam int SCALE_W   = 16;
    localparam int OFF_W     = 13;
    localparam int QUAL_W    = 8;

    // product of a clamped coordinate and the scale, shared multiplier width
    localparam int PROD_W    = DAC_W + SCALE_W;
    // step count and divider widths
    localparam int N_W       = $clog2(MAX_STEPS + 1);
    localparam int MAG_W     = DAC_W + FRAC_BITS;
    localparam int ACC_W     = MAG_W + 1;
    localparam int DIV_CNT_W = $clog2(MAG_W + 1);

    // apb register map
    localparam int APB_DW    = 32;
    localparam int REG_CNT   = 8;
    localparam int APB_AW    = $clog2(REG_CNT) + 2;

    typedef enum logic [$clog2(REG_CNT)-1:0] {
        REG_MIN_X    = 3'd0,
        REG_MAX_X    = 3'd1,
        REG_MIN_Y    = 3'd2,
        REG_MAX_Y    = 3'd3,
        REG_SCALE    = 3'd4,
        REG_OFFSET_X = 3'd5,
        REG_OFFSET_Y = 3'd6,
        REG_QUALITY  = 3'd7
    } t_reg_idx;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_CLAMP  = 12'b0000_0000_0010,
        S_MULX   = 12'b0000_0000_0100,
        S_MULY   = 12'b0000_0000_1000,
        S_PLACEY = 12'b0000_0001_0000,
        S_DIST   = 12'b0000_0010_0000,
        S_MULN   = 12'b0000_0100_0000,
        S_STEPS  = 12'b0000_1000_0000,
        S_DIVX   = 12'b0001_0000_0000,
        S_DIVY   = 12'b0010_0000_0000,
        S_EMIT   = 12'b0100_0000_0000,
        S_LAST   = 12'b1000_0000_0000
    } t_state;

endpackage

/* rtl/core/gli_if.sv */
// valid/ready channel interfaces for target points and dac points
interface gli_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [gli_pkg::TGT_W-1:0]    target_x;
    logic signed [gli_pkg::TGT_W-1:0]    target_y;

    modport source (output valid, output target_x, output target_y, input ready);
    modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

interface gli_out_if;
    logic                         valid;
    logic                         ready;
    logic [gli_pkg::DAC_W-1:0]    dac_x;
    logic [gli_pkg::DAC_W-1:0]    dac_y;
    logic                         is_endpoint;

    modport source (output valid, output dac_x, output dac_y, output is_endpoint, input ready);
    modport sink   (input valid, input dac_x, input dac_y, input is_endpoint, output ready);
endinterface

/* rtl/core/gli_div.sv */
// bit-serial restoring divider for the per-step increment
module gli_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gli_pkg::MAG_W-1:0]   i_dividend,
    input  logic [gli_pkg::N_W-1:0]     i_divisor,
    output logic                        o_done,
    output logic [gli_pkg::MAG_W-1:0]   o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [gli_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [gli_pkg::N_W-1:0]           r_rem;
    logic [gli_pkg::N_W-1:0]           r_div;
    logic [gli_pkg::MAG_W-1:0]         r_quo;

    logic [gli_pkg::N_W:0]             rem_sh;
    logic [gli_pkg::N_W:0]             rem_sub;
    logic                              q_bit;

    // one quotient bit a cycle
    always_comb begin
        rem_sh  = {r_rem, r_quo[gli_pkg::MAG_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        q_bit   = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= gli_pkg::DIV_CNT_W'(gli_pkg::MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == gli_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[gli_pkg::N_W-1:0] : rem_sh[gli_pkg::N_W-1:0];
            r_quo <= {r_quo[gli_pkg::MAG_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/galvo_line_interpolator.sv */
// top level: clamp, scale, step count and line walk of galvo targets
// a short move (step count at most 1) emits only the endpoint; a longer one runs the
// bit-serial divider twice, for x then y, then walks one output point a cycle while
// the output is not stalled; a new target is taken only once the sequencer is idle
// reset: synchronous active-low; registers back to defaults, beam position to zero
module galvo_line_interpolator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gli_in_if.sink                        i_in,
    gli_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gli_pkg::APB_AW-1:0]    paddr,
    input  logic [gli_pkg::APB_DW-1:0]    pwdata,
    output logic [gli_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int SH_W  = gli_pkg::PROD_W - gli_pkg::FRAC_BITS;
    localparam int SAT_W = SH_W + 2;

    // configuration registers
    logic [gli_pkg::DAC_W-1:0]          r_min_x, r_max_x, r_min_y, r_max_y;
    logic [gli_pkg::SCALE_W-1:0]        r_scale;
    logic signed [gli_pkg::OFF_W-1:0]   r_off_x, r_off_y;
    logic [gli_pkg::QUAL_W-1:0]         r_qual;

    // sequencer and datapath registers
    gli_pkg::t_state                    r_state, n_state;
    logic signed [gli_pkg::TGT_W-1:0]   r_tx, r_ty;
    logic [gli_pkg::DAC_W-1:0]          r_cx, r_cy;
    logic [gli_pkg::DAC_W-1:0]          r_nx, r_ny;
    logic [gli_pkg::DAC_W-1:0]          r_beam_x, r_beam_y;
    logic [gli_pkg::DAC_W-1:0]          r_ax, r_ay, r_amax;
    logic                               r_sx, r_sy;
    logic [gli_pkg::PROD_W-1:0]         r_prod;
    logic [gli_pkg::N_W-1:0]            r_n, r_i;
    logic signed [gli_pkg::ACC_W-1:0]   r_inc_x, r_inc_y;
    logic signed [gli_pkg::ACC_W-1:0]   r_acc_x, r_acc_y;

    // output register
    logic                               r_o_valid;
    logic [gli_pkg::DAC_W-1:0]          r_o_x, r_o_y;
    logic                               r_o_end;

    // combinational helpers
    logic                               cfg_wr;
    logic [$clog2(gli_pkg::REG_CNT)-1:0] cfg_idx;
    logic                               in_take;
    logic                               out_free;
    logic [gli_pkg::DAC_W-1:0]          mul_a;
    logic [gli_pkg::SCALE_W-1:0]        mul_b;
    logic [gli_pkg::DAC_W-1:0]          clamp_x, clamp_y;
    logic [gli_pkg::DAC_W-1:0]          sat_val;
    logic signed [gli_pkg::DAC_W:0]     dx, dy;
    logic [gli_pkg::DAC_W-1:0]          ax, ay;
    logic [SH_W-1:0]                    n_full;
    logic [gli_pkg::N_W-1:0]            n_cap;
    logic                               div_start;
    logic [gli_pkg::MAG_W-1:0]          div_dividend;
    logic [gli_pkg::N_W-1:0]            div_divisor;
    logic                               div_done;
    logic [gli_pkg::MAG_W-1:0]          div_quo;
    logic signed [gli_pkg::ACC_W-1:0]   inc_signed;
    logic signed [gli_pkg::ACC_W-1:0]   acc_x_nx, acc_y_nx;
    logic signed [gli_pkg::ACC_W-1:0]   pt_x, pt_y;

    // ---------------------------------------------------------------
    // apb configuration port, no wait states
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[gli_pkg::APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_max_x <= gli_pkg::DAC_W'(gli_pkg::DAC_MAX);
            r_min_y <= '0;
            r_max_y <= gli_pkg::DAC_W'(gli_pkg::DAC_MAX);
            r_scale <= gli_pkg::SCALE_W'(16);
            r_off_x <= '0;
            r_off_y <= '0;
            r_qual  <= gli_pkg::QUAL_W'(4);
        end else if (cfg_wr) begin
            unique case (gli_pkg::t_reg_idx'(cfg_idx))
                gli_pkg::REG_MIN_X:    r_min_x <= pwdata[gli_pkg::DAC_W-1:0];
                gli_pkg::REG_MAX_X:    r_max_x <= pwdata[gli_pkg::DAC_W-1:0];
                gli_pkg::REG_MIN_Y:    r_min_y <= pwdata[gli_pkg::DAC_W-1:0];
                gli_pkg::REG_MAX_Y:    r_max_y <= pwdata[gli_pkg::DAC_W-1:0];
                gli_pkg::REG_SCALE:    r_scale <= pwdata[gli_pkg::SCALE_W-1:0];
                gli_pkg::REG_OFFSET_X: r_off_x <= pwdata[gli_pkg::OFF_W-1:0];
                gli_pkg::REG_OFFSET_Y: r_off_y <= pwdata[gli_pkg::OFF_W-1:0];
                gli_pkg::REG_QUALITY:  r_qual  <= pwdata[gli_pkg::QUAL_W-1:0];
                default: ;
            endcase
        end
    end

    // read back, offsets sign-extended
    always_comb begin
        unique case (gli_pkg::t_reg_idx'(cfg_idx))
            gli_pkg::REG_MIN_X:    prdata = gli_pkg::APB_DW'(r_min_x);
            gli_pkg::REG_MAX_X:    prdata = gli_pkg::APB_DW'(r_max_x);
            gli_pkg::REG_MIN_Y:    prdata = gli_pkg::APB_DW'(r_min_y);
            gli_pkg::REG_MAX_Y:    prdata = gli_pkg::APB_DW'(r_max_y);
            gli_pkg::REG_SCALE:    prdata = gli_pkg::APB_DW'(r_scale);
            gli_pkg::REG_OFFSET_X: prdata = gli_pkg::APB_DW'(r_off_x);
            gli_pkg::REG_OFFSET_Y: prdata = gli_pkg::APB_DW'(r_off_y);
            gli_pkg::REG_QUALITY:  prdata = gli_pkg::APB_DW'(r_qual);
            default:               prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    assign i_in.ready        = (r_state == gli_pkg::S_IDLE);
    assign in_take           = i_in.valid && i_in.ready;
    assign out_free          = !r_o_valid || o_out.ready;
    assign o_out.valid       = r_o_valid;
    assign o_out.dac_x       = r_o_x;
    assign o_out.dac_y       = r_o_y;
    assign o_out.is_endpoint = r_o_end;

    // ---------------------------------------------------------------
    // clamp: x takes the lower bound first so an inverted range gives max_x,
    // y takes the upper bound first so an inverted range gives min_y
    // ---------------------------------------------------------------
    always_comb begin
        if (r_tx > $signed({{(gli_pkg::TGT_W-gli_pkg::DAC_W){1'b0}}, r_max_x})) begin
            clamp_x = r_max_x;
        end else if (r_tx < $signed({{(gli_pkg::TGT_W-gli_pkg::DAC_W){1'b0}}, r_min_x})) begin
            clamp_x = (r_min_x > r_max_x) ? r_max_x : r_min_x;
        end else begin
            clamp_x = r_tx[gli_pkg::DAC_W-1:0];
        end
        if (r_ty < $signed({{(gli_pkg::TGT_W-gli_pkg::DAC_W){1'b0}}, r_min_y})) begin
            clamp_y = r_min_y;
        end else if (r_ty > $signed({{(gli_pkg::TGT_W-gli_pkg::DAC_W){1'b0}}, r_max_y})) begin
            clamp_y = (r_min_y > r_max_y) ? r_min_y : r_max_y;
        end else begin
            clamp_y = r_ty[gli_pkg::DAC_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // shared multiplier: scale x, scale y, then distance times quality
    // ---------------------------------------------------------------
    always_comb begin
        unique case (r_state)
            gli_pkg::S_MULX: begin
                mul_a = r_cx;
                mul_b = r_scale;
            end
            gli_pkg::S_MULY: begin
                mul_a = r_cy;
                mul_b = r_scale;
            end
            gli_pkg::S_MULN: begin
                mul_a = r_amax;
                mul_b = gli_pkg::SCALE_W'(r_qual);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= gli_pkg::PROD_W'(mul_a) * gli_pkg::PROD_W'(mul_b);
    end

    // drop fraction bits, add the offset of the axis just scaled, saturate to dac range
    always_comb begin
        logic signed [SAT_W-1:0] v;
        logic signed [gli_pkg::OFF_W-1:0] off;
        off = (r_state == gli_pkg::S_MULY) ? r_off_x : r_off_y;
        v   = $signed({2'b00, r_prod[gli_pkg::PROD_W-1:gli_pkg::FRAC_BITS]})
            + $signed({{(SAT_W-gli_pkg::OFF_W){off[gli_pkg::OFF_W-1]}}, off});
        if (v < 0) begin
            sat_val = '0;
        end else if (v > $signed(SAT_W'(gli_pkg::DAC_MAX))) begin
            sat_val = gli_pkg::DAC_W'(gli_pkg::DAC_MAX);
        end else begin
            sat_val = v[gli_pkg::DAC_W-1:0];
        end
    end

    // distance to the stored beam position
    always_comb begin
        dx = $signed({1'b0, r_nx}) - $signed({1'b0, r_beam_x});
        dy = $signed({1'b0, r_ny}) - $signed({1'b0, r_beam_y});
        ax = dx[gli_pkg::DAC_W] ? gli_pkg::DAC_W'(-dx) : dx[gli_pkg::DAC_W-1:0];
        ay = dy[gli_pkg::DAC_W] ? gli_pkg::DAC_W'(-dy) : dy[gli_pkg::DAC_W-1:0];
    end

    // step count, capped
    always_comb begin
        n_full = r_prod[gli_pkg::PROD_W-1:gli_pkg::FRAC_BITS];
        if (n_full > SH_W'(gli_pkg::MAX_STEPS)) begin
            n_cap = gli_pkg::N_W'(gli_pkg::MAX_STEPS);
        end else begin
            n_cap = n_full[gli_pkg::N_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // divider: x increment started from the step count, y on x completion
    // ---------------------------------------------------------------
    assign div_start = ((r_state == gli_pkg::S_STEPS) && (n_cap > gli_pkg::N_W'(1)))
                    || ((r_state == gli_pkg::S_DIVX) && div_done);
    assign div_dividend = (r_state == gli_pkg::S_STEPS)
                        ? {r_ax, gli_pkg::FRAC_BITS'(0)}
                        : {r_ay, gli_pkg::FRAC_BITS'(0)};
    // product is gone once the x division runs, so y takes the held step count
    assign div_divisor  = (r_state == gli_pkg::S_STEPS) ? n_cap : r_n;

    gli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // quotient truncated toward zero, sign of the move applied afterwards
    always_comb begin
        logic sgn;
        sgn        = (r_state == gli_pkg::S_DIVX) ? r_sx : r_sy;
        inc_signed = sgn ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    end

    // next point: accumulator floored to whole dac codes by arithmetic shift
    always_comb begin
        acc_x_nx = r_acc_x + r_inc_x;
        acc_y_nx = r_acc_y + r_inc_y;
        pt_x     = $signed(gli_pkg::ACC_W'(r_beam_x)) + (acc_x_nx >>> gli_pkg::FRAC_BITS);
        pt_y     = $signed(gli_pkg::ACC_W'(r_beam_y)) + (acc_y_nx >>> gli_pkg::FRAC_BITS);
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gli_pkg::S_IDLE:   if (in_take) n_state = gli_pkg::S_CLAMP;
            gli_pkg::S_CLAMP:  n_state = gli_pkg::S_MULX;
            gli_pkg::S_MULX:   n_state = gli_pkg::S_MULY;
            gli_pkg::S_MULY:   n_state = gli_pkg::S_PLACEY;
            gli_pkg::S_PLACEY: n_state = gli_pkg::S_DIST;
            gli_pkg::S_DIST:   n_state = gli_pkg::S_MULN;
            gli_pkg::S_MULN:   n_state = gli_pkg::S_STEPS;
            gli_pkg::S_STEPS: begin
                // short move goes straight to the endpoint
                n_state = (n_cap > gli_pkg::N_W'(1)) ? gli_pkg::S_DIVX : gli_pkg::S_LAST;
            end
            gli_pkg::S_DIVX:   if (div_done) n_state = gli_pkg::S_DIVY;
            gli_pkg::S_DIVY:   if (div_done) n_state = gli_pkg::S_EMIT;
            gli_pkg::S_EMIT: begin
                if (out_free && (r_i == r_n - 1'b1)) n_state = gli_pkg::S_LAST;
            end
            gli_pkg::S_LAST:   if (out_free) n_state = gli_pkg::S_IDLE;
            default:           n_state = gli_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gli_pkg::S_IDLE;
            r_beam_x  <= '0;
            r_beam_y  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out.ready) r_o_valid <= 1'b0;
            if ((r_state == gli_pkg::S_EMIT || r_state == gli_pkg::S_LAST) && out_free) begin
                r_o_valid <= 1'b1;
            end
            if (r_state == gli_pkg::S_LAST && out_free) begin
                r_beam_x <= r_nx;
                r_beam_y <= r_ny;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_tx <= i_in.target_x;
            r_ty <= i_in.target_y;
        end
        unique case (r_state)
            gli_pkg::S_CLAMP: begin
                r_cx <= clamp_x;
                r_cy <= clamp_y;
            end
            gli_pkg::S_MULY:   r_nx <= sat_val;
            gli_pkg::S_PLACEY: r_ny <= sat_val;
            gli_pkg::S_DIST: begin
                r_ax   <= ax;
                r_ay   <= ay;
                r_sx   <= dx[gli_pkg::DAC_W];
                r_sy   <= dy[gli_pkg::DAC_W];
                r_amax <= (ax > ay) ? ax : ay;
            end
            gli_pkg::S_STEPS: begin
                r_n     <= n_cap;
                r_i     <= gli_pkg::N_W'(1);
                r_acc_x <= '0;
                r_acc_y <= '0;
            end
            gli_pkg::S_DIVX:   if (div_done) r_inc_x <= inc_signed;
            gli_pkg::S_DIVY:   if (div_done) r_inc_y <= inc_signed;
            gli_pkg::S_EMIT: begin
                if (out_free) begin
                    r_acc_x <= acc_x_nx;
                    r_acc_y <= acc_y_nx;
                    r_i     <= r_i + 1'b1;
                    r_o_x   <= pt_x[gli_pkg::DAC_W-1:0];
                    r_o_y   <= pt_y[gli_pkg::DAC_W-1:0];
                    r_o_end <= 1'b0;
                end
            end
            gli_pkg::S_LAST: begin
                if (out_free) begin
                    r_o_x   <= r_nx;
                    r_o_y   <= r_ny;
                    r_o_end <= 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

/* verif/galvo_line_interpolator_tb.sv */
// testbench for the galvo line interpolator: clamp, scale and line walk checked per dac point
`timescale 1ns / 1ps

typedef struct packed {
    logic [gli_pkg::DAC_W-1:0] x;
    logic [gli_pkg::DAC_W-1:0] y;
    logic                      endpoint;
} t_dac_point;

// mirror of the register file and beam position, plus the queue of points still owed
class galvo_point_board;
    logic [gli_pkg::DAC_W-1:0]        lo_x, hi_x, lo_y, hi_y;
    logic [gli_pkg::SCALE_W-1:0]      scale;
    logic signed [gli_pkg::OFF_W-1:0] off_x, off_y;
    logic [gli_pkg::QUAL_W-1:0]       quality;
    logic [gli_pkg::DAC_W-1:0]        beam_x, beam_y;
    t_dac_point                       pending_points[$];
    int                               mismatches;

    function new();
        lo_x = 0;
        hi_x = gli_pkg::DAC_MAX;
        lo_y = 0;
        hi_y = gli_pkg::DAC_MAX;
        scale = 16;
        off_x = 0;
        off_y = 0;
        quality = 4;
        beam_x = 0;
        beam_y = 0;
        mismatches = 0;
    endfunction

    function void set_reg(gli_pkg::t_reg_idx idx, logic [gli_pkg::APB_DW-1:0] value);
        case (idx)
            gli_pkg::REG_MIN_X:    lo_x = value[gli_pkg::DAC_W-1:0];
            gli_pkg::REG_MAX_X:    hi_x = value[gli_pkg::DAC_W-1:0];
            gli_pkg::REG_MIN_Y:    lo_y = value[gli_pkg::DAC_W-1:0];
            gli_pkg::REG_MAX_Y:    hi_y = value[gli_pkg::DAC_W-1:0];
            gli_pkg::REG_SCALE:    scale = value[gli_pkg::SCALE_W-1:0];
            gli_pkg::REG_OFFSET_X: off_x = value[gli_pkg::OFF_W-1:0];
            gli_pkg::REG_OFFSET_Y: off_y = value[gli_pkg::OFF_W-1:0];
            gli_pkg::REG_QUALITY:  quality = value[gli_pkg::QUAL_W-1:0];
            default: ;
        endcase
    endfunction

    // scaled, offset and saturated dac code of a clamped coordinate
    function longint dac_code(longint c, longint off);
        longint s, v;
        s = scale;
        v = ((c * s) >>> gli_pkg::FRAC_BITS) + off;
        if (v < 0)
            v = 0;
        if (v > gli_pkg::DAC_MAX)
            v = gli_pkg::DAC_MAX;
        return v;
    endfunction

    // per-step increment, quotient truncated toward zero
    function longint step_size(longint d, longint n);
        longint mag, q;
        mag = (d < 0 ? -d : d) <<< gli_pkg::FRAC_BITS;
        q = mag / n;
        return d < 0 ? -q : q;
    endfunction

    function void add_target(logic signed [gli_pkg::TGT_W-1:0] tgt_x,
                             logic signed [gli_pkg::TGT_W-1:0] tgt_y);
        longint tx, ty, nx, ny, bx, by, dx, dy, ax, ay, amax, n;
        longint inc_x, inc_y, acc_x, acc_y, px, py, q;
        tx = tgt_x;
        ty = tgt_y;
        // x: lower clamp then upper, y: upper clamp then lower
        if (tx < longint'(lo_x))
            tx = lo_x;
        if (tx > longint'(hi_x))
            tx = hi_x;
        if (ty > longint'(hi_y))
            ty = hi_y;
        if (ty < longint'(lo_y))
            ty = lo_y;
        nx = dac_code(tx, longint'(off_x));
        ny = dac_code(ty, longint'(off_y));
        bx = beam_x;
        by = beam_y;
        dx = nx - bx;
        dy = ny - by;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        amax = ax > ay ? ax : ay;
        q = quality;
        n = (amax * q) >>> gli_pkg::FRAC_BITS;
        if (n > gli_pkg::MAX_STEPS)
            n = gli_pkg::MAX_STEPS;
        if (n > 1) begin
            inc_x = step_size(dx, n);
            inc_y = step_size(dy, n);
            acc_x = 0;
            acc_y = 0;
            for (longint i = 1; i < n; i++) begin
                acc_x += inc_x;
                acc_y += inc_y;
                px = bx + (acc_x >>> gli_pkg::FRAC_BITS);
                py = by + (acc_y >>> gli_pkg::FRAC_BITS);
                pending_points.push_back('{px[gli_pkg::DAC_W-1:0], py[gli_pkg::DAC_W-1:0],
                                           1'b0});
            end
        end
        beam_x = nx[gli_pkg::DAC_W-1:0];
        beam_y = ny[gli_pkg::DAC_W-1:0];
        pending_points.push_back('{nx[gli_pkg::DAC_W-1:0], ny[gli_pkg::DAC_W-1:0], 1'b1});
    endfunction

    function void check_point(logic [gli_pkg::DAC_W-1:0] x, logic [gli_pkg::DAC_W-1:0] y,
                              logic endpoint);
        t_dac_point want;
        if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected dac point x=%0d y=%0d end=%0b, nothing pending",
                         x, y, endpoint);
            return;
        end
        want = pending_points.pop_front();
        if (want.x !== x || want.y !== y || want.endpoint !== endpoint) begin
            mismatches++;
            if (mismatches <= 10)
                $display("dac point mismatch: expected x=%0d y=%0d end=%0b, got x=%0d y=%0d end=%0b",
                         want.x, want.y, want.endpoint, x, y, endpoint);
        end
    endfunction
endclass

module galvo_line_interpolator_tb;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [gli_pkg::APB_AW-1:0]     paddr;
    logic [gli_pkg::APB_DW-1:0]     pwdata;
    logic [gli_pkg::APB_DW-1:0]     prdata;
    logic                           pready;

    // output side handshake, starts low so the port is never unknown
    logic                  out_ready = 1'b0;
    int                    ready_hold = 0;

    // when clear neither side idles, giving back-to-back stretches
    bit                    idle_on;

    // last requested target, so that short moves can be aimed near it
    int                    last_x;
    int                    last_y;

    galvo_point_board      board;

    gli_in_if  in_ch ();
    gli_out_if out_ch ();

    assign out_ch.ready = out_ready;

    galvo_line_interpolator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // stall length: three bands drawn with weights 75, 20 and 5 percent, each longer than the last
    function automatic int stall_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (!idle_on)
            return 0;
        if ($urandom_range(0, 1) == 0)
            return 0;
        return stall_length();
    endfunction

    // receiver back-pressure, one nonblocking update of ready per edge
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            out_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            out_ready <= 1'b0;
            ready_hold = stall_length() - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // every dac point transaction goes to the board as it is accepted
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_point(out_ch.dac_x, out_ch.dac_y, out_ch.is_endpoint);
    end

    // one target transaction; called just after a rising edge, returns just after one.
    // valid is only lowered when a gap follows, so back-to-back targets keep it high
    task automatic drive_target(logic signed [gli_pkg::TGT_W-1:0] x,
                                logic signed [gli_pkg::TGT_W-1:0] y);
        int gap;
        in_ch.valid    <= 1'b1;
        in_ch.target_x <= x;
        in_ch.target_y <= y;
        do @(posedge i_clk); while (!in_ch.ready);
        board.add_target(x, y);
        last_x = x;
        last_y = y;
        gap = sender_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // setup phase, access phase, then an idle phase so psel never toggles within a step
    task automatic apb_write(gli_pkg::t_reg_idx idx, logic [gli_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        board.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    // stop sending and let every owed point drain; the extra cycles cover the
    // final state of the walk so that the block is back in idle
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (board.pending_points.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic load_setup(int lx, int hx, int ly, int hy, int sc, int ox, int oy, int q);
        settle_block();
        apb_write(gli_pkg::REG_MIN_X, 32'(lx));
        apb_write(gli_pkg::REG_MAX_X, 32'(hx));
        apb_write(gli_pkg::REG_MIN_Y, 32'(ly));
        apb_write(gli_pkg::REG_MAX_Y, 32'(hy));
        apb_write(gli_pkg::REG_SCALE, 32'(sc));
        apb_write(gli_pkg::REG_OFFSET_X, 32'(ox));
        apb_write(gli_pkg::REG_OFFSET_Y, 32'(oy));
        apb_write(gli_pkg::REG_QUALITY, 32'(q));
    endtask

    function automatic int rand_scale();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(4, 40);
        return $urandom_range(0, 65535);
    endfunction

    function automatic int rand_offset();
        if ($urandom_range(0, 99) < 75)
            return int'($urandom_range(0, 1000)) - 500;
        return int'($urandom_range(0, 8191)) - 4096;
    endfunction

    function automatic int rand_quality();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 48);
        return $urandom_range(0, 255);
    endfunction

    // new settings for one random phase; phases 0, 1 and 3 are fixed corners, phase 2 has inverted bounds
    task automatic random_setup(int phase);
        case (phase)
            0: load_setup(0, gli_pkg::DAC_MAX, 0, gli_pkg::DAC_MAX, 16, 0, 0, 4);
            1: load_setup(0, gli_pkg::DAC_MAX, 0, gli_pkg::DAC_MAX, 65535, -4096, 4095, 255);
            2: load_setup($urandom_range(2048, 4095), $urandom_range(0, 2047),
                          $urandom_range(2048, 4095), $urandom_range(0, 2047),
                          rand_scale(), rand_offset(), rand_offset(), rand_quality());
            3: load_setup(gli_pkg::DAC_MAX, gli_pkg::DAC_MAX, 0, 0, 0, 4095, -4096, 0);
            default: load_setup($urandom_range(0, 2047), $urandom_range(2048, 4095),
                                $urandom_range(0, 2047), $urandom_range(2048, 4095),
                                rand_scale(), rand_offset(), rand_offset(), rand_quality());
        endcase
    endtask

    // mostly targets near the last one or inside the dac range, the rest anywhere
    function automatic logic signed [gli_pkg::TGT_W-1:0] pick_coord(int near);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return gli_pkg::TGT_W'(near + int'($urandom_range(0, 40)) - 20);
        if (r < 75)
            return gli_pkg::TGT_W'($urandom_range(0, gli_pkg::DAC_MAX));
        return gli_pkg::TGT_W'($urandom_range(0, 65535));
    endfunction

    initial begin
        board = new();
        idle_on = 1'b0;
        last_x = 0;
        last_y = 0;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.target_x <= '0;
        in_ch.target_y <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: unit scale, quality 4
        drive_target(16'sd0, 16'sd0);              // no move at all
        drive_target(16'sd4095, 16'sd4095);        // long move, step count capped
        drive_target(-16'sd32768, 16'sd32767);     // both clamps at their far ends
        drive_target(16'sd32767, -16'sd32768);
        drive_target(-16'sd1, 16'sd21845);
        drive_target(-16'sd21846, 16'sd4091);      // distance 4, a single step
        drive_target(16'sd8, 16'sd4091);           // two steps, one point between
        drive_target(16'sd20, 16'sd4080);
        drive_target(16'sd100, 16'sd3900);

        // inverted bounds: max wins on x, min wins on y
        load_setup(3000, 1000, 3000, 1000, 16, 0, 0, 4);
        drive_target(16'sd500, 16'sd500);
        drive_target(16'sd4000, 16'sd4000);

        // top of every range, offsets at opposite extremes
        load_setup(0, gli_pkg::DAC_MAX, 0, gli_pkg::DAC_MAX, 65535, -4096, 4095, 255);
        drive_target(16'sd0, 16'sd0);
        drive_target(16'sd1, 16'sd1);
        drive_target(16'sd2, 16'sd0);
        drive_target(16'sd4095, 16'sd32767);

        // zero scale and zero quality: endpoint only, no division
        load_setup(0, gli_pkg::DAC_MAX, 0, gli_pkg::DAC_MAX, 0, 4095, -4096, 0);
        drive_target(16'sd1234, 16'sd4000);
        drive_target(-16'sd5, 16'sd99);

        // half scale, one step per dac unit
        load_setup(100, 3900, 100, 3900, 8, 100, -100, 16);
        drive_target(16'sd3900, 16'sd50);
        drive_target(16'sd0, 16'sd4095);
        drive_target(16'sd2048, 16'sd2048);
        drive_target(16'sd2049, 16'sd2047);

        // random phases, each under its own register settings
        for (int phase = 0; phase < 6; phase++) begin
            random_setup(phase);
            idle_on = 1'b1;
            for (int k = 0; k < 35; k++) begin
                if ($urandom_range(0, 15) == 0)
                    idle_on = !idle_on;
                drive_target(pick_coord(last_x), pick_coord(last_y));
            end
        end

        idle_on = 1'b0;
        settle_block();
        // room for any stray point from a walk of full length
        repeat (120) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending_points.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* galvo_line_interpolator.f */
rtl/core/gli_pkg.sv
rtl/core/gli_if.sv
rtl/core/gli_div.sv
rtl/core/galvo_line_interpolator.sv
verif/galvo_line_interpolator_tb.sv
